### hw/rtl/mba_pkg.sv
package mba_pkg;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [15:0] SEL_BANK_TWO      = 16'h8000;
  localparam logic [15:0] SEL_BANK_THREE    = 16'hC001;
  localparam logic [15:0] APIC_BASE_INDEX   = 16'h001B;
  localparam logic [15:0] PLATFORM_ID_INDEX = 16'h0017;
  localparam logic [15:0] MTRR_FIRST_INDEX  = 16'h0200;
  localparam logic [15:0] MTRR_LAST_INDEX   = 16'h0207;

  localparam logic [31:0] APIC_LOW_MASK  = 32'h0000_0FFF;
  localparam logic [63:0] APIC_BASE_BSP  = 64'h0000_0000_FEE0_0900;
  localparam logic [63:0] APIC_BASE_AP   = 64'h0000_0000_FEE0_0800;
  localparam logic [63:0] PLATFORM_ID    = {32'(2 << 'h12), 32'h0000_0000};

  localparam logic [63:0] MTRR_RESET [8] = '{
    64'h0000_0000_0000_0006, 64'h0000_00FF_C000_0800,
    64'h0000_0000_4000_0006, 64'h0000_00FF_E000_0800,
    64'h0000_0000_6000_0006, 64'h0000_00FF_F000_0800,
    64'h0000_0000_7000_0006, 64'h0000_00FF_F800_0800
  };

  typedef struct packed {
    logic clear_en;
    logic issue;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_sts_t;

  function automatic logic [63:0] bank_one_reset(logic [15:0] idx, logic is_bsp);
    logic [63:0] val;
    val = 64'h0;
    if (idx inside {[MTRR_FIRST_INDEX:MTRR_LAST_INDEX]}) begin
      val = MTRR_RESET[idx[2:0]];
    end else if (idx == APIC_BASE_INDEX) begin
      val = is_bsp ? APIC_BASE_BSP : APIC_BASE_AP;
    end else if (idx == PLATFORM_ID_INDEX) begin
      val = PLATFORM_ID;
    end
    return val;
  endfunction

endpackage

### hw/rtl/mba_if.sv
interface mba_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] msr_address;
  logic [1:0]  privilege_level;
  logic [31:0] write_low;
  logic [31:0] write_high;

  modport source (
    output valid, action, msr_address, privilege_level, write_low, write_high,
    input  ready
  );
  modport sink (
    input  valid, action, msr_address, privilege_level, write_low, write_high,
    output ready
  );
endinterface

interface mba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_low;
  logic [31:0] read_high;
  logic        protection_fault;
  logic        apic_base_update;
  logic [31:0] apic_base_address;

  modport source (
    output valid, read_low, read_high, protection_fault, apic_base_update,
           apic_base_address,
    input  ready
  );
  modport sink (
    input  valid, read_low, read_high, protection_fault, apic_base_update,
           apic_base_address,
    output ready
  );
endinterface

### hw/rtl/mba_ctrl.sv
module mba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mba_pkg::dp_cmd_t cmd_o,
  input  mba_pkg::dp_sts_t sts_i
);
  import mba_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign cmd_o.clear_en    = (state_q == ST_CLEAR);
  assign cmd_o.issue       = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.load_result = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clear_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (cmd_o.load_result) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cmd_o.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // one transaction in flight between accept and result
  a_issue_blocks_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |=> !in_ready_o)
    else $error("input accepted again right after issue");

  a_load_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |=> out_valid_o)
    else $error("loaded result not presented");

  a_resp_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && out_valid_q && !out_ready_i) |=> state_q == ST_RESP)
    else $error("result dropped while output stalled");

endmodule

### hw/rtl/mba_datapath.sv
module mba_datapath #(
  parameter int unsigned BANK_ONE_SIZE   = 1024,
  parameter int unsigned BANK_TWO_SIZE   = 256,
  parameter int unsigned BANK_THREE_SIZE = 256,
  parameter bit          IS_BOOTSTRAP    = 1'b1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mba_pkg::dp_cmd_t cmd_i,
  output mba_pkg::dp_sts_t sts_o,
  input  logic             action_i,
  input  logic [31:0]      msr_address_i,
  input  logic [1:0]       privilege_level_i,
  input  logic [31:0]      write_low_i,
  input  logic [31:0]      write_high_i,
  output logic [31:0]      read_low_o,
  output logic [31:0]      read_high_o,
  output logic             protection_fault_o,
  output logic             apic_base_update_o,
  output logic [31:0]      apic_base_address_o
);
  import mba_pkg::*;

  localparam int unsigned ONE_W   = (BANK_ONE_SIZE > 1) ? $clog2(BANK_ONE_SIZE) : 1;
  localparam int unsigned TWO_W   = (BANK_TWO_SIZE > 1) ? $clog2(BANK_TWO_SIZE) : 1;
  localparam int unsigned THREE_W = (BANK_THREE_SIZE > 1) ? $clog2(BANK_THREE_SIZE) : 1;
  localparam int unsigned MAX_12  = (BANK_ONE_SIZE > BANK_TWO_SIZE) ? BANK_ONE_SIZE
                                                                      : BANK_TWO_SIZE;
  localparam int unsigned MAX_SIZE = (MAX_12 > BANK_THREE_SIZE) ? MAX_12 : BANK_THREE_SIZE;
  localparam int unsigned CNT_W   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  typedef enum logic [1:0] {
    BANK_ONE,
    BANK_TWO,
    BANK_THREE
  } bank_e;

  logic [63:0] mem_one_q   [BANK_ONE_SIZE];
  logic [63:0] mem_two_q   [BANK_TWO_SIZE];
  logic [63:0] mem_three_q [BANK_THREE_SIZE];

  logic [CNT_W-1:0] clr_cnt_q;
  logic [16:0]      clr_row;

  logic [15:0] sel;
  logic [15:0] idx;
  bank_e       bank;
  logic [16:0] bank_size;
  logic        fault;
  logic        wr_ok;
  logic [63:0] wdata;

  logic               one_we, two_we, three_we;
  logic [ONE_W-1:0]   one_addr;
  logic [TWO_W-1:0]   two_addr;
  logic [THREE_W-1:0] three_addr;
  logic [63:0]        one_wdata;
  logic [63:0]        one_rd_q, two_rd_q, three_rd_q;

  bank_e       bank_q;
  logic        fault_q;
  logic        write_q;
  logic        apic_q;
  logic [31:0] wlo_q;

  logic [31:0] read_low_q, read_high_q, apic_addr_q;
  logic        fault_out_q, apic_upd_q;

  // request decode
  always_comb begin
    sel   = msr_address_i[31:16];
    idx   = msr_address_i[15:0];
    wdata = {write_high_i, write_low_i};
    case (sel)
      SEL_BANK_TWO: begin
        bank      = BANK_TWO;
        bank_size = 17'(BANK_TWO_SIZE);
      end
      SEL_BANK_THREE: begin
        bank      = BANK_THREE;
        bank_size = 17'(BANK_THREE_SIZE);
      end
      default: begin
        bank      = BANK_ONE;
        bank_size = 17'(BANK_ONE_SIZE);
      end
    endcase
    fault = (privilege_level_i != 2'd0) || ({1'b0, idx} >= bank_size);
    wr_ok = cmd_i.issue && (action_i == ACT_WRITE) && !fault;
  end

  // clearing pass after reset
  assign clr_row          = 17'(clr_cnt_q);
  assign sts_o.clear_last = (clr_cnt_q == CNT_W'(MAX_SIZE - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_cnt_q <= clr_cnt_q + CNT_W'(1);
    end
  end

  // memory port muxing
  always_comb begin
    one_addr   = idx[ONE_W-1:0];
    two_addr   = idx[TWO_W-1:0];
    three_addr = idx[THREE_W-1:0];
    one_wdata  = wdata;
    if (cmd_i.clear_en) begin
      one_we     = (clr_row < 17'(BANK_ONE_SIZE));
      two_we     = (clr_row < 17'(BANK_TWO_SIZE));
      three_we   = (clr_row < 17'(BANK_THREE_SIZE));
      one_addr   = clr_cnt_q[ONE_W-1:0];
      two_addr   = clr_cnt_q[TWO_W-1:0];
      three_addr = clr_cnt_q[THREE_W-1:0];
      one_wdata  = bank_one_reset(16'(clr_cnt_q), IS_BOOTSTRAP);
    end else begin
      one_we   = wr_ok && (bank == BANK_ONE);
      two_we   = wr_ok && (bank == BANK_TWO);
      three_we = wr_ok && (bank == BANK_THREE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (one_we) mem_one_q[one_addr] <= one_wdata;
    if (cmd_i.issue) one_rd_q <= mem_one_q[one_addr];
  end

  always_ff @(posedge clk_i) begin
    if (two_we) mem_two_q[two_addr] <= cmd_i.clear_en ? 64'h0 : wdata;
    if (cmd_i.issue) two_rd_q <= mem_two_q[two_addr];
  end

  always_ff @(posedge clk_i) begin
    if (three_we) mem_three_q[three_addr] <= cmd_i.clear_en ? 64'h0 : wdata;
    if (cmd_i.issue) three_rd_q <= mem_three_q[three_addr];
  end

  // request info for the result stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      bank_q  <= bank;
      fault_q <= fault;
      write_q <= (action_i == ACT_WRITE);
      apic_q  <= (bank == BANK_ONE) && (idx == APIC_BASE_INDEX);
      wlo_q   <= write_low_i;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      read_low_q  <= 32'h0;
      read_high_q <= 32'h0;
      fault_out_q <= 1'b0;
      apic_upd_q  <= 1'b0;
      apic_addr_q <= 32'h0;
      if (fault_q) begin
        fault_out_q <= 1'b1;
      end else if (write_q) begin
        apic_upd_q  <= apic_q;
        apic_addr_q <= apic_q ? (wlo_q & ~APIC_LOW_MASK) : 32'h0;
      end else begin
        case (bank_q)
          BANK_TWO: begin
            read_low_q  <= two_rd_q[31:0];
            read_high_q <= two_rd_q[63:32];
          end
          BANK_THREE: begin
            read_low_q  <= three_rd_q[31:0];
            read_high_q <= three_rd_q[63:32];
          end
          default: begin
            read_low_q  <= one_rd_q[31:0];
            read_high_q <= one_rd_q[63:32];
          end
        endcase
      end
    end
  end

  assign read_low_o          = read_low_q;
  assign read_high_o         = read_high_q;
  assign protection_fault_o  = fault_out_q;
  assign apic_base_update_o  = apic_upd_q;
  assign apic_base_address_o = apic_addr_q;

endmodule

### hw/rtl/msr_bank_access_unit.sv
// result path: memory read and request info registers, then the output register;
// a result is held only while an earlier one still waits on the response side
// requests: a new one is taken only once the last result is loaded (registered
// memory read, then result stage); a new request is taken while a result waits
// reset: asynchronous, active low; then a clearing pass over max(bank sizes) rows
// (1024 by default) loads reset values while the request side is not ready
module msr_bank_access_unit #(
  parameter int unsigned BANK_ONE_SIZE   = 1024,
  parameter int unsigned BANK_TWO_SIZE   = 256,
  parameter int unsigned BANK_THREE_SIZE = 256,
  parameter bit          IS_BOOTSTRAP    = 1'b1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mba_req_if.sink        req_i,
  mba_rsp_if.source      rsp_o
);
  import mba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;
  logic    out_valid;

  mba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mba_datapath #(
    .BANK_ONE_SIZE   (BANK_ONE_SIZE),
    .BANK_TWO_SIZE   (BANK_TWO_SIZE),
    .BANK_THREE_SIZE (BANK_THREE_SIZE),
    .IS_BOOTSTRAP    (IS_BOOTSTRAP)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .action_i            (req_i.action),
    .msr_address_i       (req_i.msr_address),
    .privilege_level_i   (req_i.privilege_level),
    .write_low_i         (req_i.write_low),
    .write_high_i        (req_i.write_high),
    .read_low_o          (rsp_o.read_low),
    .read_high_o         (rsp_o.read_high),
    .protection_fault_o  (rsp_o.protection_fault),
    .apic_base_update_o  (rsp_o.apic_base_update),
    .apic_base_address_o (rsp_o.apic_base_address)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule

### sim/msr_bank_access_unit_tb.sv
module msr_bank_access_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mba_pkg::*;

  localparam int unsigned ONE_SIZE   = 1024;
  localparam int unsigned TWO_SIZE   = 256;
  localparam int unsigned THREE_SIZE = 256;
  localparam int unsigned N_RANDOM   = 1500;

  typedef enum int {BANK_ONE, BANK_TWO, BANK_THREE} bank_e;

  typedef struct packed {
    logic        action;
    logic [31:0] addr;
    logic [1:0]  cpl;
    logic [31:0] wlo;
    logic [31:0] whi;
  } msr_access_t;

  typedef struct packed {
    logic [31:0] rlo;
    logic [31:0] rhi;
    logic        fault;
    logic        apic_upd;
    logic [31:0] apic_addr;
  } msr_result_t;

  logic clk_i;
  logic rst_ni;

  mba_req_if req_if ();
  mba_rsp_if rsp_if ();

  msr_bank_access_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  logic [63:0] bank_one_m   [ONE_SIZE];
  logic [63:0] bank_two_m   [TWO_SIZE];
  logic [63:0] bank_three_m [THREE_SIZE];

  msr_access_t access_q [$];
  msr_result_t result_q [$];

  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned n_reads;
  int unsigned n_writes;
  int unsigned n_faults;
  int unsigned n_apic;
  int unsigned err_cnt;
  bit          req_taken;
  bit          no_idle;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic load_reset_values();
    logic [63:0] mtrr_defaults [8];
    mtrr_defaults = '{
      64'h0000_0000_0000_0006, 64'h0000_00FF_C000_0800,
      64'h0000_0000_4000_0006, 64'h0000_00FF_E000_0800,
      64'h0000_0000_6000_0006, 64'h0000_00FF_F000_0800,
      64'h0000_0000_7000_0006, 64'h0000_00FF_F800_0800
    };
    foreach (bank_one_m[i]) bank_one_m[i] = '0;
    foreach (bank_two_m[i]) bank_two_m[i] = '0;
    foreach (bank_three_m[i]) bank_three_m[i] = '0;
    for (int i = 0; i < 8; i++) begin
      bank_one_m[MTRR_FIRST_INDEX + i] = mtrr_defaults[i];
    end
    bank_one_m[APIC_BASE_INDEX]   = 64'h0000_0000_FEE0_0900;
    bank_one_m[PLATFORM_ID_INDEX] = {32'h0008_0000, 32'h0000_0000};
  endtask

  // applies one access to the shadow banks and returns what the block must answer
  function automatic msr_result_t access_msr(msr_access_t a);
    logic [15:0] sel;
    logic [15:0] idx;
    int unsigned size;
    bank_e       bank;
    logic [63:0] val;
    msr_result_t r;
    sel = a.addr[31:16];
    idx = a.addr[15:0];
    r   = '0;
    if (sel == SEL_BANK_TWO) begin
      bank = BANK_TWO;
      size = TWO_SIZE;
    end else if (sel == SEL_BANK_THREE) begin
      bank = BANK_THREE;
      size = THREE_SIZE;
    end else begin
      bank = BANK_ONE;
      size = ONE_SIZE;
    end
    if (a.cpl != 2'd0 || idx >= size) begin
      r.fault = 1'b1;
      return r;
    end
    if (a.action == ACT_WRITE) begin
      case (bank)
        BANK_TWO:   bank_two_m[idx]   = {a.whi, a.wlo};
        BANK_THREE: bank_three_m[idx] = {a.whi, a.wlo};
        default:    bank_one_m[idx]   = {a.whi, a.wlo};
      endcase
      if (bank == BANK_ONE && idx == APIC_BASE_INDEX) begin
        r.apic_upd  = 1'b1;
        r.apic_addr = a.wlo & ~APIC_LOW_MASK;
      end
    end else begin
      case (bank)
        BANK_TWO:   val = bank_two_m[idx];
        BANK_THREE: val = bank_three_m[idx];
        default:    val = bank_one_m[idx];
      endcase
      r.rlo = val[31:0];
      r.rhi = val[63:32];
    end
    return r;
  endfunction

  function automatic msr_access_t mk(logic act, logic [15:0] sel, logic [15:0] idx,
                                     logic [1:0] cpl, logic [31:0] wlo, logic [31:0] whi);
    msr_access_t a;
    a.action = act;
    a.addr   = {sel, idx};
    a.cpl    = cpl;
    a.wlo    = wlo;
    a.whi    = whi;
    return a;
  endfunction

  function automatic msr_access_t rand_access();
    msr_access_t a;
    logic [15:0] sel;
    logic [15:0] idx;
    int unsigned size;
    int unsigned pick;
    a.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
    a.cpl    = ($urandom_range(0, 99) < 80) ? 2'd0 : 2'($urandom_range(1, 3));
    case ($urandom_range(0, 2))
      0: begin
        sel  = SEL_BANK_TWO;
        size = TWO_SIZE;
      end
      1: begin
        sel  = SEL_BANK_THREE;
        size = THREE_SIZE;
      end
      default: begin
        sel = ($urandom_range(0, 1)) ? 16'($urandom) : 16'h0000;
        if (sel == SEL_BANK_TWO || sel == SEL_BANK_THREE) sel = 16'h0000;
        size = ONE_SIZE;
      end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      idx = 16'($urandom);
    end else if (pick < 15) begin
      idx = 16'(size) - 16'($urandom_range(0, 1));
    end else if (pick < 45) begin
      case ($urandom_range(0, 3))
        0:       idx = APIC_BASE_INDEX;
        1:       idx = PLATFORM_ID_INDEX;
        2:       idx = MTRR_FIRST_INDEX + 16'($urandom_range(0, 7));
        default: idx = 16'($urandom_range(0, 7));
      endcase
    end else begin
      idx = 16'($urandom_range(0, size - 1));
    end
    a.addr = {sel, idx};
    a.wlo  = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
    a.whi  = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
    return a;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // request driver
  always @(negedge clk_i) begin
    msr_access_t nxt;
    if (rst_ni && (!req_if.valid || req_taken)) begin
      req_taken = 1'b0;
      if (access_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 30)) begin
        nxt = access_q.pop_front();
        req_if.valid           <= 1'b1;
        req_if.action          <= nxt.action;
        req_if.msr_address     <= nxt.addr;
        req_if.privilege_level <= nxt.cpl;
        req_if.write_low       <= nxt.wlo;
        req_if.write_high      <= nxt.whi;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
    rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 30);
  end

  // monitor
  always @(posedge clk_i) begin
    msr_access_t acc;
    msr_result_t exp_r;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        acc.action = req_if.action;
        acc.addr   = req_if.msr_address;
        acc.cpl    = req_if.privilege_level;
        acc.wlo    = req_if.write_low;
        acc.whi    = req_if.write_high;
        exp_r = access_msr(acc);
        result_q.push_back(exp_r);
        if (exp_r.fault) n_faults++;
        else if (acc.action == ACT_WRITE) n_writes++;
        else n_reads++;
        n_accepted++;
        req_taken = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        n_results++;
        if (result_q.size() == 0) begin
          $display("%0t unexpected result transaction: read %h_%h fault %b apic %b %h",
                   $time, rsp_if.read_high, rsp_if.read_low, rsp_if.protection_fault,
                   rsp_if.apic_base_update, rsp_if.apic_base_address);
          err_cnt++;
        end else begin
          exp_r = result_q.pop_front();
          if (rsp_if.apic_base_update === 1'b1) n_apic++;
          check_field("read_low", exp_r.rlo, rsp_if.read_low);
          check_field("read_high", exp_r.rhi, rsp_if.read_high);
          check_field("protection_fault", 32'(exp_r.fault), 32'(rsp_if.protection_fault));
          check_field("apic_base_update", 32'(exp_r.apic_upd), 32'(rsp_if.apic_base_update));
          check_field("apic_base_address", exp_r.apic_addr, rsp_if.apic_base_address);
        end
      end
    end
    no_idle = (n_accepted >= 500 && n_accepted < 800);
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni                 = 1'b0;
    req_if.valid           = 1'b0;
    req_if.action          = ACT_READ;
    req_if.msr_address     = '0;
    req_if.privilege_level = '0;
    req_if.write_low       = '0;
    req_if.write_high      = '0;
    rsp_if.ready           = 1'b0;
    n_accepted = 0;
    n_results  = 0;
    n_reads    = 0;
    n_writes   = 0;
    n_faults   = 0;
    n_apic     = 0;
    err_cnt    = 0;
    req_taken  = 1'b0;
    no_idle    = 1'b0;
    load_reset_values();

    // reset contents
    access_q.push_back(mk(ACT_READ, 16'h0000, APIC_BASE_INDEX, 2'd0, '0, '0));
    access_q.push_back(mk(ACT_READ, 16'h0000, PLATFORM_ID_INDEX, 2'd0, '0, '0));
    access_q.push_back(mk(ACT_READ, 16'h0000, MTRR_FIRST_INDEX, 2'd0, '0, '0));
    access_q.push_back(mk(ACT_READ, 16'hFFFF, MTRR_LAST_INDEX, 2'd0, '0, '0));
    // bank one bounds
    access_q.push_back(mk(ACT_READ, 16'h0000, 16'd1023, 2'd0, '0, '0));
    access_q.push_back(mk(ACT_READ, 16'h1234, 16'd1024, 2'd0, '0, '0));
    access_q.push_back(mk(ACT_WRITE, 16'h0000, 16'hFFFF, 2'd0, '1, '1));
    // apic base write and read back
    access_q.push_back(mk(ACT_WRITE, 16'h0000, APIC_BASE_INDEX, 2'd0, 32'hFFFF_FFFF, '1));
    access_q.push_back(mk(ACT_READ, 16'h0000, APIC_BASE_INDEX, 2'd0, '0, '0));
    // privilege faults, also ahead of bounds faults
    access_q.push_back(mk(ACT_READ, 16'h0000, APIC_BASE_INDEX, 2'd1, '0, '0));
    access_q.push_back(mk(ACT_WRITE, 16'h0000, 16'd5, 2'd3, '1, '1));
    access_q.push_back(mk(ACT_READ, 16'h0000, 16'd5, 2'd0, '0, '0));
    access_q.push_back(mk(ACT_WRITE, SEL_BANK_THREE, 16'hFFFF, 2'd2, '1, '1));
    // bank two
    access_q.push_back(mk(ACT_WRITE, SEL_BANK_TWO, 16'd255, 2'd0, '1, '1));
    access_q.push_back(mk(ACT_READ, SEL_BANK_TWO, 16'd255, 2'd0, '0, '0));
    access_q.push_back(mk(ACT_READ, SEL_BANK_TWO, 16'd256, 2'd0, '0, '0));
    access_q.push_back(mk(ACT_WRITE, SEL_BANK_TWO, 16'd256, 2'd0, '1, '1));
    access_q.push_back(mk(ACT_WRITE, SEL_BANK_TWO, APIC_BASE_INDEX, 2'd0, 32'hFEE0_1ABC, '0));
    // bank three, reads bounded like writes
    access_q.push_back(mk(ACT_WRITE, SEL_BANK_THREE, 16'd255, 2'd0, 32'h8000_0001, 32'h8000_0001));
    access_q.push_back(mk(ACT_READ, SEL_BANK_THREE, 16'd255, 2'd0, '0, '0));
    access_q.push_back(mk(ACT_READ, SEL_BANK_THREE, 16'd256, 2'd0, '0, '0));
    access_q.push_back(mk(ACT_WRITE, SEL_BANK_THREE, 16'd256, 2'd0, '1, '1));
    access_q.push_back(mk(ACT_WRITE, SEL_BANK_THREE, APIC_BASE_INDEX, 2'd0, '1, '1));
    access_q.push_back(mk(ACT_READ, SEL_BANK_THREE, APIC_BASE_INDEX, 2'd0, '0, '0));
    for (int i = 0; i < N_RANDOM; i++) begin
      access_q.push_back(rand_access());
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (access_q.size() != 0 || req_if.valid) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("accesses %0d: reads %0d, writes %0d, faults %0d", n_accepted, n_reads,
             n_writes, n_faults);
    $display("results checked %0d, apic base updates seen %0d", n_results, n_apic);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
